// File: hw/rtl/eev_pkg.sv
// eev_pkg: types, constants and register indexes of the elf64 executable validator
// used by every module under hw/rtl; depends on nothing
package eev_pkg;

  localparam int unsigned DefMaxSegments = 16;
  localparam int unsigned DefPageBytes   = 4096;
  localparam int unsigned DefOffsetBits  = 32;

  localparam int unsigned HdrBytes = 64;
  localparam int unsigned EntBytes = 56;

  localparam logic [31:0] ElfMagic    = 32'h464C_457F;
  localparam logic [7:0]  ElfClass64  = 8'd2;
  localparam logic [7:0]  ElfDataLe   = 8'd1;
  localparam logic [15:0] ElfTypeExec = 16'd2;
  localparam logic [31:0] ElfVersion  = 32'd1;
  localparam logic [15:0] ElfEhSize   = 16'd64;
  localparam logic [15:0] ElfPhEntSz  = 16'd56;
  localparam logic [31:0] PtLoad      = 32'd1;

  localparam logic [63:0] DefRegionBase  = 64'h0000_0000_0100_0000;
  localparam logic [63:0] DefRegionLimit = 64'h0000_0000_0200_0000;
  localparam logic [15:0] DefMachine     = 16'd183;

  typedef enum logic [1:0] {
    RegRegionBase  = 2'd0,
    RegRegionLimit = 2'd1,
    RegMachineCode = 2'd2,
    RegUnused      = 2'd3
  } cfg_reg_e;

  // header byte positions at which a field is complete
  localparam logic [5:0] PosMagic   = 6'd3;
  localparam logic [5:0] PosClass   = 6'd4;
  localparam logic [5:0] PosData    = 6'd5;
  localparam logic [5:0] PosType    = 6'd17;
  localparam logic [5:0] PosMachine = 6'd19;
  localparam logic [5:0] PosVersion = 6'd23;
  localparam logic [5:0] PosEntry   = 6'd31;
  localparam logic [5:0] PosPhOff   = 6'd39;
  localparam logic [5:0] PosShOff   = 6'd47;
  localparam logic [5:0] PosFlags   = 6'd51;
  localparam logic [5:0] PosEhSize  = 6'd53;
  localparam logic [5:0] PosPhEnt   = 6'd55;
  localparam logic [5:0] PosPhNum   = 6'd57;

  typedef logic [6:0][63:0] seg_words_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic        reject;
    logic        ext_upd;
    logic [63:0] extent;
    logic        hit;
  } seg_res_t;

endpackage

// File: hw/rtl/eev_in_reg.sv
// eev_in_reg: input register that holds one byte word ahead of the state update
// uses eev_pkg for the word type
module eev_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  eev_pkg::in_word_t in_word_i,
  input  logic              take_i,
  output logic              valid_o,
  output eev_pkg::in_word_t word_o
);
  import eev_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// File: hw/rtl/eev_seg_check.sv
// eev_seg_check: checks of one captured program header against the region and entry
// uses eev_pkg for the capture and result types; PAGE_BYTES is a power of two
module eev_seg_check #(
  parameter int unsigned PAGE_BYTES = eev_pkg::DefPageBytes
) (
  input  eev_pkg::seg_words_t words_i,
  input  logic [63:0]         entry_i,
  input  logic [63:0]         base_i,
  input  logic [63:0]         limit_i,
  output eev_pkg::seg_res_t   res_o
);
  import eev_pkg::*;

  localparam logic [63:0] AlignMask = 64'(PAGE_BYTES - 1);

  logic [31:0] p_type;
  logic [31:0] p_flags;
  logic [63:0] off, va, pa, fsz, msz, al, vend;
  logic [64:0] vsum, osum;
  logic        is_load, bad_attr, bad_vwrap, bad_end, bad_owrap, bad;

  always_comb begin
    p_type  = words_i[0][31:0];
    p_flags = words_i[0][63:32];
    off     = words_i[1];
    va      = words_i[2];
    pa      = words_i[3];
    fsz     = words_i[4];
    msz     = words_i[5];
    al      = words_i[6];
    vsum    = {1'b0, va} + {1'b0, msz};
    osum    = {1'b0, off} + {1'b0, fsz};
    vend    = vsum[63:0];

    is_load   = (p_type == PtLoad);
    // writable and executable together is refused
    bad_attr  = (p_flags[1:0] == 2'b11) || (va < base_i) || (va >= limit_i) || (va != pa);
    bad_vwrap = vsum[64];
    bad_end   = (vend < base_i) || (vend >= limit_i) || ((al & AlignMask) != 64'd0);
    bad_owrap = osum[64];
    bad       = bad_attr || bad_vwrap || bad_end || bad_owrap;

    res_o.reject  = is_load && bad;
    res_o.ext_upd = is_load && !bad;
    res_o.extent  = osum[63:0];
    res_o.hit     = is_load && !bad && p_flags[0] && (entry_i >= va) && (entry_i < vend);
  end

endmodule

// File: hw/rtl/elf64_executable_validator_top.sv
// ELF64 executable validator. Bytes of one file enter one word per cycle on the input
// channel, the last byte flagged; each byte is held in an input register and then folded
// into the header and program header checks with no further stage, so the block takes one
// byte every cycle. On the last byte one verdict word (accepted, entry point) goes to an
// output register; the next byte starts a new file while that verdict waits to be taken.
// Input stalls only when a second verdict is due and the first has not been taken.
// Depends on eev_pkg, eev_in_reg and eev_seg_check.
module elf64_executable_validator_top #(
  parameter int unsigned MAX_SEGMENTS = eev_pkg::DefMaxSegments,
  parameter int unsigned PAGE_BYTES   = eev_pkg::DefPageBytes,
  parameter int unsigned OFFSET_BITS  = eev_pkg::DefOffsetBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  file_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [63:0] entry_point_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import eev_pkg::*;

  // configuration
  logic [63:0] base_q, limit_q;
  logic [15:0] mach_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= DefRegionBase;
      limit_q <= DefRegionLimit;
      mach_q  <= DefMachine;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegRegionBase:  base_q  <= cfg_data_i;
        RegRegionLimit: limit_q <= cfg_data_i;
        RegMachineCode: mach_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input stage
  in_word_t in_word, s1_word;
  logic     s1_valid, s1_take, out_valid_q;

  assign in_word.data = file_byte_i;
  assign in_word.last = final_byte_i;
  assign s1_take = s1_valid && (!s1_word.last || !out_valid_q || out_ready_i);

  eev_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word),
    .take_i     (s1_take),
    .valid_o    (s1_valid),
    .word_o     (s1_word)
  );

  // file state
  logic [OFFSET_BITS-1:0] cnt_q, cnt_d;
  logic [63:0] gather_q, gather_d, entry_q, entry_d, tbl_q, tbl_d, sect_q, sect_d;
  logic [63:0] ext_q, ext_d;
  logic [15:0] total_q, total_d, seen_q, seen_d;
  logic [5:0]  sbyte_q, sbyte_d;
  logic [1:0]  hits_q, hits_d;
  logic        rej_q, rej_d;
  seg_words_t  seg_q, seg_d, seg_cap;
  seg_res_t    seg_res;
  logic        acc_q, acc_d, ok;
  logic [63:0] out_entry_q, out_entry_d;

  logic [63:0] pos64, g;
  logic [15:0] nseg;
  logic [21:0] span;
  logic [64:0] tbl_end;
  logic        capture;
  logic [7:0]  b;

  assign b     = s1_word.data;
  assign pos64 = 64'(cnt_q);

  // byte inserted into the capture word; the first byte of a word clears it
  always_comb begin
    seg_cap = seg_q;
    seg_cap[sbyte_q[5:3]][{sbyte_q[2:0], 3'b000} +: 8] = b;
    if (sbyte_q[2:0] == 3'd0) begin
      seg_cap[sbyte_q[5:3]][63:8] = 56'd0;
    end
  end

  eev_seg_check #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_seg_check (
    .words_i (seg_cap),
    .entry_i (entry_q),
    .base_i  (base_q),
    .limit_i (limit_q),
    .res_o   (seg_res)
  );

  always_comb begin
    cnt_d       = cnt_q;
    gather_d    = gather_q;
    entry_d     = entry_q;
    tbl_d       = tbl_q;
    sect_d      = sect_q;
    ext_d       = ext_q;
    total_d     = total_q;
    seen_d      = seen_q;
    sbyte_d     = sbyte_q;
    hits_d      = hits_q;
    rej_d       = rej_q;
    seg_d       = seg_q;
    acc_d       = acc_q;
    out_entry_d = out_entry_q;
    capture     = 1'b0;
    g           = {b, gather_q[63:8]};
    nseg        = g[63:48];
    span        = 22'(nseg) * 22'(EntBytes);
    tbl_end     = {1'b0, tbl_q} + 65'(span);
    ok          = 1'b0;

    if (s1_take) begin
      if (&cnt_q) begin
        rej_d = 1'b1;
      end else begin
        cnt_d = cnt_q + OFFSET_BITS'(1);
        if (!rej_q) begin
          if (pos64 < 64'(HdrBytes)) begin
            gather_d = g;
            case (cnt_q[5:0])
              PosMagic:   if (g[63:32] != ElfMagic) rej_d = 1'b1;
              PosClass:   if (b != ElfClass64) rej_d = 1'b1;
              PosData:    if (b != ElfDataLe) rej_d = 1'b1;
              PosType:    if (g[63:48] != ElfTypeExec) rej_d = 1'b1;
              PosMachine: if (g[63:48] != mach_q) rej_d = 1'b1;
              PosVersion: if (g[63:32] != ElfVersion) rej_d = 1'b1;
              PosEntry: begin
                entry_d = g;
                if (g < base_q || g >= limit_q) rej_d = 1'b1;
              end
              PosPhOff: begin
                tbl_d = g;
                if (g < 64'(HdrBytes)) rej_d = 1'b1;
              end
              PosShOff: begin
                sect_d = g;
                if (g > ext_q) ext_d = g;
              end
              PosFlags:   if (g[63:60] != 4'd0) rej_d = 1'b1;
              PosEhSize:  if (g[63:48] != ElfEhSize) rej_d = 1'b1;
              PosPhEnt:   if (g[63:48] != ElfPhEntSz) rej_d = 1'b1;
              PosPhNum: begin
                total_d = nseg;
                if (nseg == 16'd0 || 32'(nseg) >= 32'(MAX_SEGMENTS)) begin
                  rej_d = 1'b1;
                end else if (tbl_end[64]) begin
                  rej_d = 1'b1;
                end else if (tbl_end[63:0] > ext_q) begin
                  ext_d = tbl_end[63:0];
                end
              end
              default: ;
            endcase
          end else if (pos64 >= tbl_q && seen_q < total_q) begin
            capture = 1'b1;
            seg_d   = seg_cap;
            sbyte_d = sbyte_q + 6'd1;
            if (sbyte_q == 6'(EntBytes - 1)) begin
              sbyte_d = 6'd0;
              seen_d  = seen_q + 16'd1;
              if (seg_res.reject) rej_d = 1'b1;
              if (seg_res.ext_upd && seg_res.extent > ext_q) ext_d = seg_res.extent;
              if (seg_res.hit) begin
                if (hits_q != 2'd0) begin
                  hits_d = 2'd2;
                  rej_d  = 1'b1;
                end else begin
                  hits_d = 2'd1;
                end
              end
            end
          end
        end
      end

      if (s1_word.last) begin
        ok = !rej_d && (64'(cnt_d) >= 64'(HdrBytes)) && (seen_d == total_d) &&
             (total_d != 16'd0) && (ext_d <= 64'(cnt_d)) && (sect_d <= 64'(cnt_d)) &&
             (hits_d == 2'd1);
        acc_d       = ok;
        out_entry_d = ok ? entry_d : 64'd0;
        // new file starts with the next byte
        cnt_d    = '0;
        gather_d = '0;
        entry_d  = '0;
        tbl_d    = '0;
        sect_d   = '0;
        ext_d    = '0;
        total_d  = '0;
        seen_d   = '0;
        sbyte_d  = '0;
        hits_d   = '0;
        rej_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      gather_q    <= '0;
      entry_q     <= '0;
      tbl_q       <= '0;
      sect_q      <= '0;
      ext_q       <= '0;
      total_q     <= '0;
      seen_q      <= '0;
      sbyte_q     <= '0;
      hits_q      <= '0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      gather_q <= gather_d;
      entry_q  <= entry_d;
      tbl_q    <= tbl_d;
      sect_q   <= sect_d;
      ext_q    <= ext_d;
      total_q  <= total_d;
      seen_q   <= seen_d;
      sbyte_q  <= sbyte_d;
      hits_q   <= hits_d;
      rej_q    <= rej_d;
      if (s1_take && s1_word.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      seg_q <= seg_d;
    end
    acc_q       <= acc_d;
    out_entry_q <= out_entry_d;
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = acc_q;
  assign entry_point_o = out_entry_q;

  a_hits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hits_q != 2'd3) else $error("exec hit count out of range");

  a_sbyte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sbyte_q < 6'(EntBytes)) else $error("segment byte index past entry size");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_take && s1_word.last |=> cnt_q == '0 && seen_q == 16'd0 && !rej_q)
    else $error("file state not cleared after verdict");

  a_verdict_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_take && s1_word.last))
    else $error("verdict without a last byte");

  a_accept_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !acc_q |-> out_entry_q == 64'd0)
    else $error("rejected verdict carries an entry address");

endmodule

// File: test/testbench.sv
// testbench for elf64_executable_validator_top: streams built and noisy elf64 files
// through the byte channel and checks each verdict against an in-line predictor
// depends on eev_pkg and the rtl under hw/rtl
`timescale 1ns / 100ps

module testbench;
  import eev_pkg::*;

  localparam logic [63:0] CountMax = (64'd1 << DefOffsetBits) - 64'd1;
  localparam logic [63:0] PageSize = 64'(DefPageBytes);

  typedef struct {
    logic        acc;
    logic [63:0] entry;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  file_byte_i = '0;
  logic        final_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        accepted_o;
  logic [63:0] entry_point_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  elf64_executable_validator_top dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [63:0] cur_base, cur_limit;
  logic [15:0] cur_machine;
  logic [63:0] nbytes, gather, entry_r, phoff_r, shoff_r, extent_max;
  logic [15:0] seg_total, seg_seen;
  logic [5:0]  seg_bcnt;
  logic [63:0] seg_cap [7];
  logic [1:0]  hits;
  logic        bad;

  verdict_t    verdict_q [$];
  logic [7:0]  img [$];
  int          errors = 0;
  int          items = 0;
  int          verdicts = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;
  bit          hold_req = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic bit in_region(input logic [63:0] a);
    return a >= cur_base && a < cur_limit;
  endfunction

  task automatic clear_file_state();
    nbytes = 0; gather = 0; entry_r = 0; phoff_r = 0; shoff_r = 0; extent_max = 0;
    seg_total = 0; seg_seen = 0; seg_bcnt = 0; hits = 0; bad = 0;
    for (int i = 0; i < 7; i++) seg_cap[i] = 0;
  endtask

  task automatic need_extent(input logic [63:0] e);
    if (e > extent_max) extent_max = e;
  endtask

  task automatic header_check(input logic [5:0] pos, input logic [7:0] b);
    logic [63:0] span;
    case (pos)
      PosMagic:   if (gather[63:32] != ElfMagic) bad = 1;
      PosClass:   if (b != ElfClass64) bad = 1;
      PosData:    if (b != ElfDataLe) bad = 1;
      PosType:    if (gather[63:48] != ElfTypeExec) bad = 1;
      PosMachine: if (gather[63:48] != cur_machine) bad = 1;
      PosVersion: if (gather[63:32] != ElfVersion) bad = 1;
      PosEntry: begin
        entry_r = gather;
        if (!in_region(gather)) bad = 1;
      end
      PosPhOff: begin
        phoff_r = gather;
        if (gather < 64'(HdrBytes)) bad = 1;
      end
      PosShOff: begin
        shoff_r = gather;
        need_extent(gather);
      end
      PosFlags:   if (gather[63:60] != 4'd0) bad = 1;
      PosEhSize:  if (gather[63:48] != ElfEhSize) bad = 1;
      PosPhEnt:   if (gather[63:48] != ElfPhEntSz) bad = 1;
      PosPhNum: begin
        seg_total = gather[63:48];
        if (seg_total < 1 || seg_total >= 16'(DefMaxSegments)) begin
          bad = 1;
        end else begin
          span = 64'(seg_total) * 64'(EntBytes);
          if (phoff_r > ~64'd0 - span) bad = 1;
          else need_extent(phoff_r + span);
        end
      end
      default: ;
    endcase
  endtask

  task automatic load_entry_check();
    logic [31:0] ptype, flags;
    logic [63:0] off, va, pa, fsz, msz, al, vend;
    ptype = seg_cap[0][31:0]; flags = seg_cap[0][63:32];
    off = seg_cap[1]; va = seg_cap[2]; pa = seg_cap[3];
    fsz = seg_cap[4]; msz = seg_cap[5]; al = seg_cap[6];
    if (ptype != PtLoad) return;
    if (flags[1:0] == 2'b11 || !in_region(va) || va != pa) begin bad = 1; return; end
    if (va > ~64'd0 - msz) begin bad = 1; return; end
    vend = va + msz;
    if (!in_region(vend) || (al % PageSize) != 0) begin bad = 1; return; end
    if (off > ~64'd0 - fsz) begin bad = 1; return; end
    need_extent(off + fsz);
    if (flags[0] && entry_r >= va && entry_r < vend) begin
      if (hits >= 1) begin hits = 2; bad = 1; end
      else hits = 1;
    end
  endtask

  // advances the predictor by one accepted word, queues a verdict on the last byte
  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic [63:0] pos;
    int w;
    verdict_t v;
    pos = nbytes;
    if (nbytes >= CountMax) begin
      bad = 1;
    end else begin
      nbytes++;
      if (!bad) begin
        if (pos < 64'(HdrBytes)) begin
          gather = {b, gather[63:8]};
          header_check(pos[5:0], b);
        end else if (pos >= phoff_r && seg_seen < seg_total) begin
          w = (seg_bcnt >> 3) % 7;
          if (seg_bcnt[2:0] == 3'd0) seg_cap[w] = 64'(b);
          else seg_cap[w] = seg_cap[w] | (64'(b) << (seg_bcnt[2:0] * 8));
          seg_bcnt++;
          if (seg_bcnt >= 6'(EntBytes)) begin
            seg_bcnt = 0;
            seg_seen++;
            load_entry_check();
          end
        end
      end
    end
    if (last) begin
      v.acc = !bad && nbytes >= 64'(HdrBytes) && seg_seen == seg_total && seg_total >= 1
              && extent_max <= nbytes && shoff_r <= nbytes && hits == 1;
      v.entry = v.acc ? entry_r : 64'd0;
      verdict_q.push_back(v);
      clear_file_state();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    file_byte_i <= b;
    final_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b, last);
    items++;
  endtask

  task automatic send_file();
    for (int i = 0; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      RegRegionBase:  cur_base = data;
      RegRegionLimit: cur_limit = data;
      RegMachineCode: cur_machine = data[15:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
  endtask

  task automatic put(input int pos, input logic [63:0] val, input int n);
    for (int i = 0; i < n; i++) img[pos + i] = val[i*8 +: 8];
  endtask

  // executable with nseg program headers; the first nexec are executable, the rest get random flags
  task automatic make_elf(input int nseg, input int nexec, input int gap);
    int phoff, total;
    logic [63:0] va;
    phoff = 64 + gap;
    total = phoff + nseg * 56 + $urandom_range(0, 16);
    img = {};
    for (int i = 0; i < total; i++) img.push_back($urandom_range(255));
    put(0, 64'h0001_0102_464C_457F, 8);
    put(8, 64'd0, 8);
    put(16, {cur_machine, ElfTypeExec}, 4);
    put(20, ElfVersion, 4);
    put(24, cur_base + 64'h100, 8);
    put(32, phoff, 8);
    put(40, ($urandom_range(3) == 0) ? 64'(total) : 64'($urandom_range(0, total)), 8);
    put(48, 64'($urandom_range(15)), 4);
    put(52, {ElfPhEntSz, ElfEhSize}, 4);
    put(56, 64'(nseg), 2);
    for (int s = 0; s < nseg; s++) begin
      va = (s < nexec) ? cur_base : cur_base + 64'h4000 * s;
      put(phoff + s*56, {(s < nexec) ? 32'd5 : 32'($urandom_range(4, 6)),
                         ($urandom_range(4) == 0) ? 32'd6 : PtLoad}, 8);
      put(phoff + s*56 + 8, 64'($urandom_range(0, 32)), 8);
      put(phoff + s*56 + 16, va, 8);
      put(phoff + s*56 + 24, va, 8);
      put(phoff + s*56 + 32, 64'($urandom_range(0, total - 32)), 8);
      put(phoff + s*56 + 40, 64'h2000, 8);
      put(phoff + s*56 + 48, PageSize * $urandom_range(0, 3), 8);
    end
  endtask

  task automatic make_noise(input int len);
    img = {};
    for (int i = 0; i < len; i++) img.push_back($urandom_range(255));
  endtask

  task automatic random_file();
    int kind;
    kind = $urandom_range(99);
    if (kind < 20) begin
      make_noise($urandom_range(1, 80));
    end else begin
      make_elf($urandom_range(1, 3), ($urandom_range(9) == 0) ? $urandom_range(0, 2) : 1,
               ($urandom_range(3) == 0) ? $urandom_range(0, 8) : 0);
      if (kind < 50) img[$urandom_range(0, img.size() - 1)] ^= 8'(1 << $urandom_range(7));
      else if (kind < 58) img = img[0:$urandom_range(0, img.size() - 1)];
    end
    send_file();
  endtask

  // receiver side: verdict check and output ready
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      verdicts++;
      if (verdict_q.size() == 0) begin
        report($sformatf("verdict with none pending, accepted=%0b", accepted_o));
      end else begin
        if (accepted_o !== verdict_q[0].acc)
          report($sformatf("accepted %0b, want %0b", accepted_o, verdict_q[0].acc));
        if (entry_point_o !== verdict_q[0].entry)
          report($sformatf("entry %h, want %h", entry_point_o, verdict_q[0].entry));
        void'(verdict_q.pop_front());
      end
    end
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    make_noise(1);  send_file();                       // one-byte file
    make_noise(63); put(0, 64'h0001_0102_464C_457F, 8); send_file(); // short file
    make_elf(1, 1, 0); send_file();                    // plain good file
    make_elf(1, 1, 0); put(32, 64'd40, 8); send_file(); // table inside the header
    make_elf(3, 1, 0); img = img[0:64 + 56 + 20]; send_file(); // entries missing
    make_elf(2, 2, 0); send_file();                    // two entry hits
    make_elf(1, 0, 0); send_file();                    // no entry hit
    make_elf(1, 1, 0); put(40, 64'hFFFF_FFFF_FFFF_FFFF, 8); send_file(); // shoff past end
    make_elf(1, 1, 0); put(96, 64'd1000, 8); send_file(); // filesz past end
    make_elf(1, 1, 0); put(64, {32'd7, PtLoad}, 8); send_file(); // writable and exec
    make_elf(1, 1, 0); put(104, 64'hFFFF_FFFF_FFFF_FFF0, 8); send_file(); // memsz wraps
    make_elf(1, 1, 0); put(112, 64'd100, 8); send_file(); // bad alignment
    make_elf(1, 1, 0); put(56, 64'd16, 2); send_file(); // too many segments
    make_elf(1, 1, 0); img[0] = 8'hFF; send_file();    // bad magic
    make_elf(2, 1, 4); send_file();                    // gap before the table
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(RegRegionBase, 64'd0);
    write_reg(RegRegionLimit, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegMachineCode, 16'hFFFF);
    write_reg(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF);
    random_file();
    write_reg(RegMachineCode, 16'h0000);
    write_reg(RegRegionLimit, 64'd0);
    random_file();
    write_reg(RegRegionBase, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(RegRegionLimit, 64'hFFFF_FFFF_FFFF_FFFF);
    random_file();
    write_reg(RegRegionBase, 64'h0000_0000_0100_0000);
    write_reg(RegRegionLimit, 64'h0000_0000_0200_0000);
    write_reg(RegMachineCode, 16'd183);
    drain();
  endtask

  task automatic test_random(input int budget);
    int stop_at;
    stop_at = items + budget;
    while (items < stop_at) random_file();
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    repeat (60) begin
      make_noise($urandom_range(1, 3));
      send_file();
    end
    drain();                                           // sender pauses until all came back
    make_elf(1, 1, 0); send_file();
    drain();
  endtask

  initial begin
    clear_file_state();
    cur_base = DefRegionBase; cur_limit = DefRegionLimit; cur_machine = DefMachine;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    send_idle_pct = 37; recv_idle_pct = 84;
    test_random(100);
    send_idle_pct = 84; recv_idle_pct = 37;
    test_random(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(100);
    test_backpressure();
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: elf64_executable_validator_top.f
hw/rtl/eev_pkg.sv
hw/rtl/eev_in_reg.sv
hw/rtl/eev_seg_check.sv
hw/rtl/elf64_executable_validator_top.sv
test/testbench.sv
